/* design/sps_pkg.sv */
// Shared types, codes and coil tables for the stepper phase sequencer.
package sps_pkg;

    localparam int unsigned KIND_W   = 2;
    localparam int unsigned COUNT_W  = 16;
    localparam int unsigned DELAY_W  = 16;
    localparam int unsigned MODE_W   = 2;
    localparam int unsigned PHASE_W  = 3;
    localparam int unsigned COILS_W  = 4;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [MODE_W-1:0]  STEP_MODE_RST  = 2'd0;
    localparam logic [DELAY_W-1:0] STEP_DELAY_RST = 16'd2;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK  = 2'd0,
        KIND_START = 2'd1,
        KIND_STOP  = 2'd2
    } t_kind;

    typedef enum logic [MODE_W-1:0] {
        MODE_HALF   = 2'd0,
        MODE_SINGLE = 2'd1,
        MODE_DUAL   = 2'd2
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_STEP_MODE  = 1'b0,
        CFG_STEP_DELAY = 1'b1
    } t_cfg_idx;

    typedef enum logic [2:0] {
        MS_STOP = 3'b001,
        MS_CW   = 3'b010,
        MS_CCW  = 3'b100
    } t_motion;

    typedef struct packed {
        logic                 wr;
        logic [CFG_IDX_W-1:0] idx;
        logic [DELAY_W-1:0]   data;
    } t_cfg_wr;

    typedef struct packed {
        logic [COILS_W-1:0] coils;
        logic               running;
        logic               move_done;
    } t_result;

    localparam logic [COILS_W-1:0] HALF_TAB [8] =
        '{4'h1, 4'h3, 4'h2, 4'h6, 4'h4, 4'hC, 4'h8, 4'h9};
    localparam logic [COILS_W-1:0] SINGLE_TAB [8] =
        '{4'h1, 4'h2, 4'h4, 4'h8, 4'h1, 4'h2, 4'h4, 4'h8};
    localparam logic [COILS_W-1:0] DUAL_TAB [8] =
        '{4'h3, 4'h6, 4'hC, 4'h9, 4'h3, 4'h6, 4'hC, 4'h9};

    // unused mode keeps the previous pattern
    function automatic logic [COILS_W-1:0] coil_decode(
        input logic [MODE_W-1:0]  mode,
        input logic [PHASE_W-1:0] phase,
        input logic [COILS_W-1:0] prev
    );
        logic [COILS_W-1:0] pat;
        case (mode)
            MODE_HALF:   pat = HALF_TAB[phase];
            MODE_SINGLE: pat = SINGLE_TAB[phase];
            MODE_DUAL:   pat = DUAL_TAB[phase];
            default:     pat = prev;
        endcase
        return pat;
    endfunction

endpackage

/* design/stepper_phase_sequencer.sv */
// Top level: request and result registers around the sequencer core.
//
// Drives the four coils of a unipolar stepper from a stream of requests.
// Request channel (i_valid/o_ready): i_kind selects a 1 ms tick, a start
// (i_direction, i_step_count, count 0 runs until stopped) or a stop.
// Result channel (o_valid/i_ready): one result per request, carrying the
// coil levels, the running flag and a move_done pulse on the completing tick.
// Config channel (i_cfg_valid/o_cfg_ready): index 0 step mode, index 1 step
// delay in ticks; always ready, to be written only while no request is in
// flight.
// A request is first held in the request register, then processed by the
// core into the result register, from which its result is offered.
// Throughput is one request per cycle while results are taken, set by the
// single core update between the two registers.
// The request register frees as its content moves on, so a new request is
// taken while a result waits; when the receiver stalls, both registers
// fill and o_ready drops until the result is taken.
// Reset: synchronous, active low; all coils off, motor stopped, phase at
// position one, step mode half-step, delay 2 ticks, both registers empty.
module stepper_phase_sequencer
    import sps_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [KIND_W-1:0]    i_kind,
    input  logic                 i_direction,
    input  logic [COUNT_W-1:0]   i_step_count,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DELAY_W-1:0]   i_cfg_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [COILS_W-1:0]   o_coils,
    output logic                 o_running,
    output logic                 o_move_done
);

    logic               r_in_vld;
    logic [KIND_W-1:0]  r_kind;
    logic               r_dir;
    logic [COUNT_W-1:0] r_count;
    logic               r_out_vld;
    t_result            r_res;

    logic    out_free;
    logic    fire;
    t_cfg_wr cfg;
    t_result res;

    assign out_free    = !r_out_vld || i_ready;
    assign fire        = r_in_vld && out_free;
    assign o_ready     = !r_in_vld || out_free;
    assign o_cfg_ready = 1'b1;

    assign cfg.wr   = i_cfg_valid;
    assign cfg.idx  = i_cfg_index;
    assign cfg.data = i_cfg_data;

    sps_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_kind       (r_kind),
        .i_direction  (r_dir),
        .i_step_count (r_count),
        .i_cfg        (cfg),
        .o_result     (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_vld <= 1'b1;
            end else if (fire) begin
                r_in_vld <= 1'b0;
            end
            if (fire) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_kind  <= i_kind;
            r_dir   <= i_direction;
            r_count <= i_step_count;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_coils     = r_res.coils;
    assign o_running   = r_res.running;
    assign o_move_done = r_res.move_done;

endmodule

/* design/sps_core.sv */
// Motion state, step timing and coil decode for one request per cycle while i_fire is high.
module sps_core
    import sps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [KIND_W-1:0]  i_kind,
    input  logic               i_direction,
    input  logic [COUNT_W-1:0] i_step_count,
    input  t_cfg_wr            i_cfg,
    output t_result            o_result
);

    logic [MODE_W-1:0]  r_mode;
    logic [DELAY_W-1:0] r_delay;
    logic [PHASE_W-1:0] r_phase,  n_phase;
    t_motion            r_motion, n_motion;
    logic [COUNT_W-1:0] r_target, n_target;
    logic [COUNT_W-1:0] r_taken,  n_taken;
    logic [DELAY_W-1:0] r_tick,   n_tick;
    logic [COILS_W-1:0] r_coils,  n_coils;

    logic [DELAY_W-1:0] delay_eff;
    logic [DELAY_W-1:0] tick_inc;
    logic               done;

    assign delay_eff = (r_delay == '0) ? DELAY_W'(1) : r_delay;
    assign tick_inc  = r_tick + DELAY_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_motion = r_motion;
        n_target = r_target;
        n_taken  = r_taken;
        n_tick   = r_tick;
        n_coils  = r_coils;
        done     = 1'b0;
        if (i_fire) begin
            unique case (i_kind)
                KIND_TICK: begin
                    if (r_motion != MS_STOP) begin
                        if (tick_inc < delay_eff) begin
                            n_tick = tick_inc;
                        end else begin
                            n_tick  = '0;
                            n_phase = (r_motion == MS_CW) ? r_phase - PHASE_W'(1)
                                                          : r_phase + PHASE_W'(1);
                            n_coils = coil_decode(r_mode, n_phase, r_coils);
                            if (r_target != '0) begin
                                n_taken = r_taken + COUNT_W'(1);
                                if (n_taken >= r_target) begin
                                    n_motion = MS_STOP;
                                    done     = 1'b1;
                                end
                            end
                        end
                    end
                end
                KIND_START: begin
                    n_motion = i_direction ? MS_CCW : MS_CW;
                    n_target = i_step_count;
                    n_taken  = '0;
                    n_tick   = '0;
                end
                KIND_STOP: begin
                    n_motion = MS_STOP;
                    n_tick   = '0;
                    n_coils  = '0;
                end
                default: ;
            endcase
        end
        // delay rewrite restarts the tick count; user writes only while idle, not enforced
        if (i_cfg.wr && i_cfg.idx == CFG_STEP_DELAY) begin
            n_tick = '0;
        end
    end

    assign o_result.coils     = n_coils;
    assign o_result.running   = (n_motion != MS_STOP);
    assign o_result.move_done = done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= STEP_MODE_RST;
            r_delay  <= STEP_DELAY_RST;
            r_phase  <= '0;
            r_motion <= MS_STOP;
            r_target <= '0;
            r_taken  <= '0;
            r_tick   <= '0;
            r_coils  <= '0;
        end else begin
            if (i_cfg.wr) begin
                unique case (i_cfg.idx)
                    CFG_STEP_MODE:  r_mode  <= i_cfg.data[MODE_W-1:0];
                    CFG_STEP_DELAY: r_delay <= i_cfg.data;
                    default: ;
                endcase
            end
            r_phase  <= n_phase;
            r_motion <= n_motion;
            r_target <= n_target;
            r_taken  <= n_taken;
            r_tick   <= n_tick;
            r_coils  <= n_coils;
        end
    end

endmodule

/* design/sps_chk.sv */
// Port-level checks for the stepper phase sequencer, bound to the top level.
module sps_chk
    import sps_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_ready,
    input logic               o_valid,
    input logic               i_ready,
    input logic [COILS_W-1:0] o_coils,
    input logic               o_running,
    input logic               o_move_done
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_coils)
            && $stable(o_running) && $stable(o_move_done))
        else $error("result changed while stalled");

    // a completed move always reports stopped
    a_done_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_move_done |-> !o_running)
        else $error("move_done while running");

    // coils only ever show a table pattern or all off
    a_coil_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_coils == 4'h0 || o_coils == 4'h1 || o_coils == 4'h2
            || o_coils == 4'h3 || o_coils == 4'h4 || o_coils == 4'h6
            || o_coils == 4'h8 || o_coils == 4'h9 || o_coils == 4'hC))
        else $error("illegal coil pattern");

    // request side backs up only behind a stalled result
    a_ready_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("request ready low without result stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind stepper_phase_sequencer sps_chk u_sps_chk (.*);

/* dv/stepper_phase_sequencer_tb.sv */
// Self-checking testbench for the stepper phase sequencer: directed plan, then random traffic.
module stepper_phase_sequencer_tb;
    import sps_pkg::*;

    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 7;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 1750;
    localparam int HOLD_CYCLES  = 64;
    localparam int HOLD_AFTER   = 500;
    localparam int MAX_PRINTS   = 50;

    localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        logic [COILS_W-1:0] coils;
        logic               running;
        logic               done;
    } t_drive;

    typedef struct packed {
        bit                 is_reg;
        t_cfg_idx           reg_idx;
        logic [KIND_W-1:0]  kind;
        logic               dir;
        logic [COUNT_W-1:0] val;
        bit                 typed;
        t_drive             want;
    } t_plan_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_ready;
    logic [KIND_W-1:0]    i_kind;
    logic                 i_direction;
    logic [COUNT_W-1:0]   i_step_count;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [DELAY_W-1:0]   i_cfg_data;
    logic                 o_valid;
    logic                 i_ready;
    logic [COILS_W-1:0]   o_coils;
    logic                 o_running;
    logic                 o_move_done;

    // motor model state
    logic [MODE_W-1:0]  mode_q;
    logic [DELAY_W-1:0] delay_q;
    logic [PHASE_W-1:0] phase_q;
    t_motion            motion_q;
    logic [COUNT_W-1:0] target_q;
    logic [COUNT_W-1:0] taken_q;
    logic [COUNT_W-1:0] tick_q;
    logic [COILS_W-1:0] coils_q;

    t_drive drive_pending[$];
    int     err_cnt      = 0;
    int     idle_cycles  = 0;
    int     results_seen = 0;
    int     burst_left   = 0;
    bit     hold_done    = 0;

    stepper_phase_sequencer i_dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic logic [COILS_W-1:0] coil_pattern(
        input logic [MODE_W-1:0]  mode,
        input logic [PHASE_W-1:0] ph,
        input logic [COILS_W-1:0] keep
    );
        logic [1:0] q;
        logic [1:0] q_next;
        case (mode)
            MODE_HALF: begin
                // even positions energize one coil, odd ones the coil and its neighbor
                q      = ph[2:1];
                q_next = q + 2'd1;
                return (4'b0001 << q) | (ph[0] ? (4'b0001 << q_next) : 4'b0000);
            end
            MODE_SINGLE: begin
                q = ph[1:0];
                return 4'b0001 << q;
            end
            MODE_DUAL: begin
                q      = ph[1:0];
                q_next = q + 2'd1;
                return (4'b0001 << q) | (4'b0001 << q_next);
            end
            default: return keep;
        endcase
    endfunction

    function automatic t_drive step_motor(
        input logic [KIND_W-1:0]  kind,
        input logic               dir,
        input logic [COUNT_W-1:0] cnt
    );
        t_drive             res;
        logic [DELAY_W-1:0] span;
        res.done = 1'b0;
        case (kind)
            KIND_TICK: begin
                if (motion_q != MS_STOP) begin
                    span   = (delay_q == '0) ? DELAY_W'(1) : delay_q;
                    tick_q = tick_q + 1'b1;
                    if (tick_q >= span) begin
                        tick_q  = '0;
                        phase_q = (motion_q == MS_CW) ? phase_q - 1'b1 : phase_q + 1'b1;
                        coils_q = coil_pattern(mode_q, phase_q, coils_q);
                        if (target_q != '0) begin
                            taken_q = taken_q + 1'b1;
                            if (taken_q >= target_q) begin
                                motion_q = MS_STOP;
                                tick_q   = '0;
                                res.done = 1'b1;
                            end
                        end
                    end
                end
            end
            KIND_START: begin
                motion_q = dir ? MS_CCW : MS_CW;
                target_q = cnt;
                taken_q  = '0;
                tick_q   = '0;
            end
            KIND_STOP: begin
                motion_q = MS_STOP;
                tick_q   = '0;
                coils_q  = '0;
            end
            default: ;
        endcase
        res.coils   = coils_q;
        res.running = (motion_q != MS_STOP);
        return res;
    endfunction

    function automatic void apply_reg(input t_cfg_idx idx, input logic [DELAY_W-1:0] data);
        if (idx == CFG_STEP_MODE) begin
            mode_q = data[MODE_W-1:0];
        end else begin
            delay_q = data;
            tick_q  = '0;
        end
    endfunction

    function automatic t_plan_row mk_req(
        input logic [KIND_W-1:0]  kind,
        input logic               dir,
        input logic [COUNT_W-1:0] val
    );
        t_plan_row row;
        row      = '0;
        row.kind = kind;
        row.dir  = dir;
        row.val  = val;
        return row;
    endfunction

    function automatic t_plan_row mk_chk(
        input logic [KIND_W-1:0]  kind,
        input logic               dir,
        input logic [COUNT_W-1:0] val,
        input logic [COILS_W-1:0] coils,
        input logic               running,
        input logic               done
    );
        t_plan_row row;
        row              = mk_req(kind, dir, val);
        row.typed        = 1'b1;
        row.want.coils   = coils;
        row.want.running = running;
        row.want.done    = done;
        return row;
    endfunction

    function automatic t_plan_row mk_reg(input t_cfg_idx idx, input logic [DELAY_W-1:0] data);
        t_plan_row row;
        row         = '0;
        row.is_reg  = 1'b1;
        row.reg_idx = idx;
        row.val     = data;
        return row;
    endfunction

    task automatic report(input string what, input int want, input int got);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("%0t mismatch %s: expected %0h got %0h", $time, what, want, got);
    endtask

    // called at a falling edge; returns at the falling edge after acceptance, valid left high
    task automatic send_req(
        input logic [KIND_W-1:0]  kind,
        input logic               dir,
        input logic [COUNT_W-1:0] cnt,
        input bit                 typed,
        input t_drive             want
    );
        int     gap;
        t_drive pred;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 1) == 1) ? $urandom_range(1, 8)
                                                     : $urandom_range(20, 80);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid      <= 1'b1;
        i_kind       <= kind;
        i_direction  <= dir;
        i_step_count <= cnt;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        pred = step_motor(kind, dir, cnt);
        drive_pending.push_back(typed ? want : pred);
        @(negedge i_clk);
    endtask

    task automatic drain_requests();
        i_valid <= 1'b0;
        while (drive_pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [DELAY_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        apply_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_drive want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (drive_pending.size() == 0) begin
                report("result with none pending", 0,
                       int'({o_coils, o_running, o_move_done}));
            end else begin
                want = drive_pending.pop_front();
                if (o_coils !== want.coils)
                    report("coils", int'(want.coils), int'(o_coils));
                if (o_running !== want.running)
                    report("running", int'(want.running), int'(o_running));
                if (o_move_done !== want.done)
                    report("move_done", int'(want.done), int'(o_move_done));
            end
        end
        if (i_rst_n && ((i_valid && o_ready) || (o_valid && i_ready)
                        || (i_cfg_valid && o_cfg_ready)))
            idle_cycles = 0;
        else
            idle_cycles++;
    end

    initial begin : result_sink
        int cyc;
        int style;
        int hold;
        cyc     = 0;
        style   = 0;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (cyc % 150 == 0) style = $urandom_range(0, 3);
            if (!hold_done && results_seen >= HOLD_AFTER && i_valid) begin
                // long back-pressure while requests keep coming
                hold_done = 1;
                i_ready <= 1'b0;
                for (hold = 0; hold < HOLD_CYCLES; hold++) @(negedge i_clk);
            end else begin
                case (style)
                    0:       i_ready <= 1'b1;
                    1:       i_ready <= 1'($urandom_range(0, 1));
                    2:       i_ready <= (cyc % 3 == 0);
                    default: i_ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("FAIL stepper_phase_sequencer");
        $finish;
    end

    initial begin : stimulus
        t_plan_row          plan[$];
        int                 sent;
        int                 n;
        int                 r;
        logic [KIND_W-1:0]  k;
        logic               d;
        logic [COUNT_W-1:0] c;
        logic [DELAY_W-1:0] data;

        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_kind       = KIND_TICK;
        i_direction  = 1'b0;
        i_step_count = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = CFG_STEP_MODE;
        i_cfg_data   = '0;

        mode_q   = STEP_MODE_RST;
        delay_q  = STEP_DELAY_RST;
        phase_q  = '0;
        motion_q = MS_STOP;
        target_q = '0;
        taken_q  = '0;
        tick_q   = '0;
        coils_q  = '0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed plan
        plan.push_back(mk_chk(KIND_TICK,  1'b1, 16'hFFFF, 4'h0, 1'b0, 1'b0));
        plan.push_back(mk_chk(KIND_SPARE, 1'b1, 16'hFFFF, 4'h0, 1'b0, 1'b0));
        plan.push_back(mk_chk(KIND_STOP,  1'b0, 16'h0000, 4'h0, 1'b0, 1'b0));
        plan.push_back(mk_chk(KIND_START, 1'b0, 16'd2,    4'h0, 1'b1, 1'b0));
        plan.push_back(mk_chk(KIND_TICK,  1'b0, 16'h0000, 4'h0, 1'b1, 1'b0));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        plan.push_back(mk_req(KIND_TICK,  1'b1, 16'h5A5A));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        // zero delay acts as one tick; unused mode keeps the coils
        plan.push_back(mk_reg(CFG_STEP_DELAY, 16'h0000));
        plan.push_back(mk_reg(CFG_STEP_MODE,  16'hFFFF));
        plan.push_back(mk_req(KIND_START, 1'b1, 16'h0000));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        plan.push_back(mk_req(KIND_START, 1'b1, 16'hFFFF));
        plan.push_back(mk_reg(CFG_STEP_MODE,  16'(MODE_SINGLE)));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        plan.push_back(mk_reg(CFG_STEP_MODE,  16'(MODE_DUAL)));
        plan.push_back(mk_reg(CFG_STEP_DELAY, 16'hFFFF));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        plan.push_back(mk_req(KIND_START, 1'b0, 16'd1));
        plan.push_back(mk_req(KIND_SPARE, 1'b0, 16'h0000));
        plan.push_back(mk_chk(KIND_STOP,  1'b1, 16'hFFFF, 4'h0, 1'b0, 1'b0));
        plan.push_back(mk_reg(CFG_STEP_DELAY, 16'd1));
        plan.push_back(mk_chk(KIND_START, 1'b0, 16'd1,    4'h0, 1'b1, 1'b0));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        plan.push_back(mk_req(KIND_START, 1'b0, 16'd2));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));
        plan.push_back(mk_req(KIND_TICK,  1'b0, 16'h0000));

        foreach (plan[i]) begin
            if (plan[i].is_reg) begin
                drain_requests();
                write_reg(plan[i].reg_idx, plan[i].val);
            end else begin
                send_req(plan[i].kind, plan[i].dir, plan[i].val, plan[i].typed, plan[i].want);
            end
        end

        // random phases, each under its own register setting
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            drain_requests();
            r = $urandom_range(0, 9);
            if (r != 0) begin
                data = DELAY_W'($urandom);
                n    = $urandom_range(0, 9);
                data[MODE_W-1:0] = (n < 3) ? MODE_HALF : (n < 6) ? MODE_SINGLE
                                 : (n < 9) ? MODE_DUAL : MODE_SPARE;
                write_reg(CFG_STEP_MODE, data);
            end
            if (r == 0 || $urandom_range(0, 3) != 0) begin
                n = $urandom_range(0, 19);
                if (n == 0)      data = '0;
                else if (n == 1) data = '1;
                else if (n == 2) data = DELAY_W'($urandom);
                else if (n < 6)  data = DELAY_W'($urandom_range(4, 9));
                else             data = DELAY_W'($urandom_range(1, 3));
                write_reg(CFG_STEP_DELAY, data);
            end
            n = $urandom_range(50, 110);
            repeat (n) begin
                r = $urandom_range(0, 99);
                d = 1'($urandom_range(0, 1));
                c = COUNT_W'($urandom);
                // while stopped, lean on starts so moves actually run
                if (motion_q == MS_STOP)
                    k = (r < 45) ? KIND_START : (r < 50) ? KIND_STOP
                      : (r < 55) ? KIND_SPARE : KIND_TICK;
                else
                    k = (r < 6) ? KIND_START : (r < 10) ? KIND_STOP
                      : (r < 13) ? KIND_SPARE : KIND_TICK;
                if (k == KIND_START) begin
                    r = $urandom_range(0, 99);
                    if (r < 8)       c = '0;
                    else if (r < 12) c = '1;
                    else if (r < 17) c = COUNT_W'($urandom);
                    else             c = COUNT_W'($urandom_range(1, 12));
                end
                sent++;
                send_req(k, d, c, 1'b0, '0);
            end
        end

        drain_requests();
        repeat (8) @(negedge i_clk);
        if (err_cnt == 0)
            $display("PASS stepper_phase_sequencer");
        else
            $display("FAIL stepper_phase_sequencer");
        $finish;
    end

endmodule
